/* rtl/look_at_matrix_builder_top_assert.svh */
// Assertion macros for the look-at matrix builder.
// Expects clk and rst_n in the scope of use.
`ifndef LOOK_AT_MATRIX_BUILDER_TOP_ASSERT_SVH
`define LOOK_AT_MATRIX_BUILDER_TOP_ASSERT_SVH

// same-cycle implication
`define LAMB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lamb assertion failed");

// next-cycle implication
`define LAMB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lamb assertion failed");

`endif

/* rtl/lamb_pkg.sv */
// Shared constants and types of the look-at matrix builder.
// No dependencies.
package lamb_pkg;

    localparam int VEC_W    = 35;   // signed normalizer input
    localparam int MAG_W    = 35;   // magnitude of normalizer input
    localparam int UNIT_W   = 18;   // signed Q2.16 unit component
    localparam int M_W      = 30;   // scaled magnitude, max in [2^29, 2^30)
    localparam int MSB_POS  = 29;
    localparam int POS_W    = 6;
    localparam int RAD_W    = 64;
    localparam int REM_W    = 34;
    localparam int ROOT_W   = 32;
    localparam int LEN_W    = 31;
    localparam int NB_W     = 18;   // numerator bits fed to the divider
    localparam int DR_W     = 33;
    localparam int SQ_ST    = 16;   // two root bits per stage
    localparam int DV_ST    = 9;    // two quotient bits per stage
    localparam int NORM_LAT = 6 + SQ_ST + DV_ST + 1;
    localparam int PROD_W   = 36;
    localparam int CR_W     = 37;

    localparam logic [31:0] Q_ONE    = 32'h0001_0000;
    localparam logic [1:0]  ROW_LAST = 2'd3;

    // data riding beside the normalizers
    typedef struct packed {
        logic [2:0][31:0]       eye;
        logic [2:0][UNIT_W-1:0] dir;
        logic                   degen;
    } lamb_side_t;

endpackage

/* rtl/look_at_matrix_builder_top.sv */
// Look-at camera-to-world matrix builder, top level.
// Depends on lamb_pkg, lamb_norm and look_at_matrix_builder_top_assert.svh.
//
// Slave channel: one word carries eye, target and up vectors (signed Q16.16).
// Master channel: four words per input word, rows 0..3 of the 4x4 matrix;
// tlast marks row 3, tuser flags the degenerate case (up parallel to the
// view direction, or a zero vector), where the identity matrix is sent.
// Datapath: input register, direction and up normalizers side by side,
// cross product (two stages), left-axis normalizer, second cross product
// and rounding (three stages), then a row sequencer that is the output
// register. Each normalizer is 32 stages: scaling, squares, a root that
// makes two bits per stage and three dividers that make two bits per stage.
// Sustained input is bounded by the four output rows per input word;
// the pipeline takes a word in any cycle in which it is not held.
// When the receiver stalls, the sequencer holds its row and the whole
// pipeline freezes once its last stage is full; nothing is dropped.
// Reset clears all valid bits and the row counter; data is not reset.
`include "look_at_matrix_builder_top_assert.svh"

module look_at_matrix_builder_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z,
    // upward_x, upward_y, upward_z (32 bits each)
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row_index[1:0], col_zero[33:2], col_one[65:34], col_two[97:66],
    // col_three[129:98], zero pad
    output logic [135:0] m_tdata,
    // degenerate
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    localparam int LAT = lamb_pkg::NORM_LAT;

    logic adv;

    // input stage
    logic                              a_vld_reg;
    logic [2:0][31:0]                  a_eye_reg;
    logic [2:0][lamb_pkg::VEC_W-1:0]   a_dif_reg, a_dif_next;
    logic [2:0][lamb_pkg::VEC_W-1:0]   a_up_reg, a_up_next;
    logic [2:0][31:0]                  in_eye;

    // first normalizer pair
    logic [2:0][lamb_pkg::UNIT_W-1:0] dir_n, upn_n;
    logic                 v1_reg [LAT];
    lamb_pkg::lamb_side_t s1_reg [LAT];

    // first cross product
    logic                       c1_vld_reg, c2_vld_reg;
    logic signed [lamb_pkg::PROD_W-1:0] c1_p_reg [6];
    logic signed [lamb_pkg::PROD_W-1:0] c1_p_next[6];
    lamb_pkg::lamb_side_t       c1_side_reg, c2_side_reg, c2_side_next;
    logic [2:0][lamb_pkg::VEC_W-1:0] c2_cr_reg, c2_cr_next;

    // left-axis normalizer
    logic [2:0][lamb_pkg::UNIT_W-1:0] left_n;
    logic                 v2_reg [LAT];
    lamb_pkg::lamb_side_t s2_reg [LAT];

    // second cross product and rounding
    logic                       d1_vld_reg, d2_vld_reg, d3_vld_reg;
    logic signed [lamb_pkg::PROD_W-1:0] d1_p_reg [6];
    logic signed [lamb_pkg::PROD_W-1:0] d1_p_next[6];
    lamb_pkg::lamb_side_t       d1_side_reg, d2_side_reg, d3_side_reg;
    logic [2:0][lamb_pkg::UNIT_W-1:0] d1_left_reg, d2_left_reg, d3_left_reg;
    logic [2:0][lamb_pkg::VEC_W-1:0]  d2_nu_reg, d2_nu_next;
    logic [2:0][31:0]                 d3_nu_reg, d3_nu_next;

    // row sequencer
    logic                             ser_vld_reg, ser_vld_next;
    logic [1:0]                       row_reg, row_next;
    logic                             ser_load, out_fire;
    lamb_pkg::lamb_side_t             ser_side_reg;
    logic [2:0][lamb_pkg::UNIT_W-1:0] ser_left_reg;
    logic [2:0][31:0]                 ser_nu_reg;
    logic [31:0]                      col0, col1, col2, col3;

    assign out_fire = ser_vld_reg && m_tready;
    assign ser_load = d3_vld_reg && (!ser_vld_reg || (out_fire && row_reg == lamb_pkg::ROW_LAST));
    assign adv      = !d3_vld_reg || ser_load;
    assign s_tready = adv;

    // input unpack, target - eye exact
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_eye[i]     = s_tdata[32*i +: 32];
            a_dif_next[i] = lamb_pkg::VEC_W'($signed(s_tdata[32*(i+3) +: 32]))
                          - lamb_pkg::VEC_W'($signed(s_tdata[32*i +: 32]));
            a_up_next[i]  = lamb_pkg::VEC_W'($signed(s_tdata[32*(i+6) +: 32]));
        end
    end

    lamb_norm u_norm_dir (
        .clk  (clk),
        .adv  (adv),
        .vec  (a_dif_reg),
        .nvec (dir_n)
    );

    lamb_norm u_norm_up (
        .clk  (clk),
        .adv  (adv),
        .vec  (a_up_reg),
        .nvec (upn_n)
    );

    // cross(upn, dir) products and difference; zero cross means degenerate
    always_comb
    begin
        logic signed [lamb_pkg::CR_W-1:0] dif;
        dif = '0;
        c1_p_next[0] = $signed(upn_n[1]) * $signed(dir_n[2]);
        c1_p_next[1] = $signed(upn_n[2]) * $signed(dir_n[1]);
        c1_p_next[2] = $signed(upn_n[2]) * $signed(dir_n[0]);
        c1_p_next[3] = $signed(upn_n[0]) * $signed(dir_n[2]);
        c1_p_next[4] = $signed(upn_n[0]) * $signed(dir_n[1]);
        c1_p_next[5] = $signed(upn_n[1]) * $signed(dir_n[0]);
        c2_side_next = c1_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            dif = lamb_pkg::CR_W'(c1_p_reg[2*i]) - lamb_pkg::CR_W'(c1_p_reg[2*i+1]);
            c2_cr_next[i] = dif[lamb_pkg::VEC_W-1:0];
        end
        c2_side_next.degen = (c2_cr_next == '0);
    end

    lamb_norm u_norm_left (
        .clk  (clk),
        .adv  (adv),
        .vec  (c2_cr_reg),
        .nvec (left_n)
    );

    // cross(dir, left) and rounding of Q32.32 to Q16.16, half away from zero
    always_comb
    begin
        logic signed [lamb_pkg::CR_W-1:0] dif;
        logic [lamb_pkg::VEC_W-1:0]       mag;
        logic [lamb_pkg::VEC_W-1:0]       rnd;
        dif = '0;
        mag = '0;
        rnd = '0;
        d1_p_next[0] = $signed(s2_reg[LAT-1].dir[1]) * $signed(left_n[2]);
        d1_p_next[1] = $signed(s2_reg[LAT-1].dir[2]) * $signed(left_n[1]);
        d1_p_next[2] = $signed(s2_reg[LAT-1].dir[2]) * $signed(left_n[0]);
        d1_p_next[3] = $signed(s2_reg[LAT-1].dir[0]) * $signed(left_n[2]);
        d1_p_next[4] = $signed(s2_reg[LAT-1].dir[0]) * $signed(left_n[1]);
        d1_p_next[5] = $signed(s2_reg[LAT-1].dir[1]) * $signed(left_n[0]);
        for (int i = 0; i < 3; i++)
        begin
            dif = lamb_pkg::CR_W'(d1_p_reg[2*i]) - lamb_pkg::CR_W'(d1_p_reg[2*i+1]);
            d2_nu_next[i] = dif[lamb_pkg::VEC_W-1:0];
            mag = d2_nu_reg[i][lamb_pkg::VEC_W-1] ? (~d2_nu_reg[i] + 1'b1) : d2_nu_reg[i];
            rnd = (mag + lamb_pkg::VEC_W'(32'h8000)) >> 16;
            d3_nu_next[i] = d2_nu_reg[i][lamb_pkg::VEC_W-1] ? -rnd[31:0] : rnd[31:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            d1_vld_reg <= 1'b0;
            d2_vld_reg <= 1'b0;
            d3_vld_reg <= 1'b0;
            for (int k = 0; k < LAT; k++)
            begin
                v1_reg[k] <= 1'b0;
                v2_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_vld_reg  <= s_tvalid;
            c1_vld_reg <= v1_reg[LAT-1];
            c2_vld_reg <= c1_vld_reg;
            d1_vld_reg <= v2_reg[LAT-1];
            d2_vld_reg <= d1_vld_reg;
            d3_vld_reg <= d2_vld_reg;
            for (int k = 0; k < LAT; k++)
            begin
                v1_reg[k] <= (k == 0) ? a_vld_reg : v1_reg[(k == 0) ? 0 : k-1];
                v2_reg[k] <= (k == 0) ? c2_vld_reg : v2_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_eye_reg <= in_eye;
            a_dif_reg <= a_dif_next;
            a_up_reg  <= a_up_next;
            for (int k = 0; k < LAT; k++)
            begin
                if (k == 0)
                begin
                    s1_reg[k].eye   <= a_eye_reg;
                    s1_reg[k].dir   <= '0;
                    s1_reg[k].degen <= 1'b0;
                    s2_reg[k]       <= c2_side_reg;
                end
                else
                begin
                    s1_reg[k] <= s1_reg[k-1];
                    s2_reg[k] <= s2_reg[k-1];
                end
            end
            c1_side_reg.eye   <= s1_reg[LAT-1].eye;
            c1_side_reg.dir   <= dir_n;
            c1_side_reg.degen <= 1'b0;
            for (int j = 0; j < 6; j++)
            begin
                c1_p_reg[j] <= c1_p_next[j];
                d1_p_reg[j] <= d1_p_next[j];
            end
            c2_side_reg <= c2_side_next;
            c2_cr_reg   <= c2_cr_next;
            d1_side_reg <= s2_reg[LAT-1];
            d1_left_reg <= left_n;
            d2_side_reg <= d1_side_reg;
            d2_left_reg <= d1_left_reg;
            d2_nu_reg   <= d2_nu_next;
            d3_side_reg <= d2_side_reg;
            d3_left_reg <= d2_left_reg;
            d3_nu_reg   <= d3_nu_next;
        end
        if (ser_load)
        begin
            ser_side_reg <= d3_side_reg;
            ser_left_reg <= d3_left_reg;
            ser_nu_reg   <= d3_nu_reg;
        end
    end

    // row sequencer
    always_comb
    begin
        ser_vld_next = ser_vld_reg;
        row_next     = row_reg;
        if (ser_load)
        begin
            ser_vld_next = 1'b1;
            row_next     = '0;
        end
        else if (out_fire)
        begin
            row_next = row_reg + 2'd1;
            if (row_reg == lamb_pkg::ROW_LAST)
            begin
                ser_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_vld_reg <= 1'b0;
            row_reg     <= '0;
        end
        else
        begin
            ser_vld_reg <= ser_vld_next;
            row_reg     <= row_next;
        end
    end

    // row mux
    always_comb
    begin
        col0 = '0;
        col1 = '0;
        col2 = '0;
        col3 = '0;
        if (ser_side_reg.degen)
        begin
            case (row_reg)
                2'd0:    col0 = lamb_pkg::Q_ONE;
                2'd1:    col1 = lamb_pkg::Q_ONE;
                2'd2:    col2 = lamb_pkg::Q_ONE;
                default: col3 = lamb_pkg::Q_ONE;
            endcase
        end
        else if (row_reg == lamb_pkg::ROW_LAST)
        begin
            col3 = lamb_pkg::Q_ONE;
        end
        else
        begin
            col0 = 32'($signed(ser_left_reg[row_reg]));
            col1 = ser_nu_reg[row_reg];
            col2 = 32'($signed(ser_side_reg.dir[row_reg]));
            col3 = ser_side_reg.eye[row_reg];
        end
    end

    assign m_tvalid   = ser_vld_reg;
    assign m_tdata    = {6'b0, col3, col2, col1, col0, row_reg};
    assign m_tuser[0] = ser_side_reg.degen;
    assign m_tlast    = (row_reg == lamb_pkg::ROW_LAST);

    `LAMB_ASSERT_IMP(a_degen_ident, m_tvalid && ser_side_reg.degen,
        col3 == ((row_reg == lamb_pkg::ROW_LAST) ? lamb_pkg::Q_ONE : 32'h0))
    `LAMB_ASSERT_NXT(a_row_step, out_fire && row_reg != lamb_pkg::ROW_LAST,
        m_tvalid && row_reg == $past(row_reg) + 2'd1)
    `LAMB_ASSERT_IMP(a_hold_cause, !s_tready, d3_vld_reg && ser_vld_reg)

endmodule

/* rtl/lamb_norm.sv */
// Pipelined vector normalizer: scale, sum of squares, root, divide.
// Depends on lamb_pkg. Every stage advances only when adv is high.
module lamb_norm (
    input  logic                                   clk,
    input  logic                                   adv,
    input  logic [2:0][lamb_pkg::VEC_W-1:0]        vec,
    output logic [2:0][lamb_pkg::UNIT_W-1:0]       nvec
);

    // front stages
    logic [2:0][lamb_pkg::MAG_W-1:0] mag_reg, mag_next, mag1_reg;
    logic [2:0]                      neg_reg, neg_next, neg1_reg, neg2_reg, neg3_reg;
    logic [2:0]                      neg4_reg, neg5_reg;
    logic [lamb_pkg::MAG_W-1:0]      mx_reg, mx_next;
    logic [2:0][lamb_pkg::MAG_W-1:0] mag2_reg;
    logic [lamb_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                            zero_reg, zero_next, zero3_reg, zero4_reg, zero5_reg;
    logic [2:0][lamb_pkg::M_W-1:0]   m_reg, m_next, m4_reg, m5_reg;
    logic [2:0][2*lamb_pkg::M_W-1:0] sqr_reg, sqr_next;
    logic [2*lamb_pkg::M_W+1:0]      sum_reg, sum_next;

    // root stages
    logic [lamb_pkg::RAD_W-1:0]  rad_reg  [lamb_pkg::SQ_ST];
    logic [lamb_pkg::RAD_W-1:0]  rad_next [lamb_pkg::SQ_ST];
    logic [lamb_pkg::REM_W-1:0]  rem_reg  [lamb_pkg::SQ_ST];
    logic [lamb_pkg::REM_W-1:0]  rem_next [lamb_pkg::SQ_ST];
    logic [lamb_pkg::ROOT_W-1:0] root_reg [lamb_pkg::SQ_ST];
    logic [lamb_pkg::ROOT_W-1:0] root_next[lamb_pkg::SQ_ST];
    logic [2:0][lamb_pkg::M_W-1:0] sm_reg [lamb_pkg::SQ_ST];
    logic [2:0]                    sn_reg [lamb_pkg::SQ_ST];
    logic                          sz_reg [lamb_pkg::SQ_ST];

    // divide stages
    logic [2:0][lamb_pkg::DR_W-1:0] dr_reg  [lamb_pkg::DV_ST];
    logic [2:0][lamb_pkg::DR_W-1:0] dr_next [lamb_pkg::DV_ST];
    logic [2:0][lamb_pkg::NB_W-1:0] nb_reg  [lamb_pkg::DV_ST];
    logic [2:0][lamb_pkg::NB_W-1:0] nb_next [lamb_pkg::DV_ST];
    logic [2:0][lamb_pkg::NB_W-1:0] q_reg   [lamb_pkg::DV_ST];
    logic [2:0][lamb_pkg::NB_W-1:0] q_next  [lamb_pkg::DV_ST];
    logic [lamb_pkg::LEN_W-1:0]     len_reg [lamb_pkg::DV_ST];
    logic [lamb_pkg::LEN_W-1:0]     len_next[lamb_pkg::DV_ST];
    logic [2:0]                     dn_reg  [lamb_pkg::DV_ST];
    logic                           dz_reg  [lamb_pkg::DV_ST];

    logic [2:0][lamb_pkg::UNIT_W-1:0] out_reg, out_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = vec[i][lamb_pkg::VEC_W-1];
            mag_next[i] = neg_next[i] ? (~vec[i] + 1'b1) : vec[i];
        end
        mx_next = mag_reg[0];
        if (mag_reg[1] > mx_next)
        begin
            mx_next = mag_reg[1];
        end
        if (mag_reg[2] > mx_next)
        begin
            mx_next = mag_reg[2];
        end
        pos_next  = '0;
        for (int b = 0; b < lamb_pkg::MAG_W; b++)
        begin
            if (mx_reg[b])
            begin
                pos_next = lamb_pkg::POS_W'(b);
            end
        end
        zero_next = (mx_reg == '0);
    end

    always_comb
    begin
        logic [lamb_pkg::MAG_W+lamb_pkg::MSB_POS-1:0] wide;
        wide = '0;
        for (int i = 0; i < 3; i++)
        begin
            wide      = {mag2_reg[i], lamb_pkg::MSB_POS'(0)} >> pos_reg;
            m_next[i] = wide[lamb_pkg::M_W-1:0];
            sqr_next[i] = m_reg[i] * m_reg[i];
        end
        sum_next = (2*lamb_pkg::M_W+2)'(sqr_reg[0]) + (2*lamb_pkg::M_W+2)'(sqr_reg[1])
                 + (2*lamb_pkg::M_W+2)'(sqr_reg[2]);
    end

    // floor square root, restoring, two result bits per stage
    always_comb
    begin
        logic [lamb_pkg::RAD_W-1:0]  rad;
        logic [lamb_pkg::REM_W+1:0]  rem2;
        logic [lamb_pkg::REM_W+1:0]  trial;
        logic [lamb_pkg::ROOT_W-1:0] root;
        rad = '0;
        rem2 = '0;
        trial = '0;
        root = '0;
        for (int k = 0; k < lamb_pkg::SQ_ST; k++)
        begin
            if (k == 0)
            begin
                rad  = lamb_pkg::RAD_W'(sum_reg);
                rem2 = '0;
                root = '0;
            end
            else
            begin
                rad  = rad_reg[k-1];
                rem2 = (lamb_pkg::REM_W+2)'(rem_reg[k-1]);
                root = root_reg[k-1];
            end
            for (int j = 0; j < 2; j++)
            begin
                rem2  = {rem2[lamb_pkg::REM_W-1:0], rad[lamb_pkg::RAD_W-1 -: 2]};
                rad   = rad << 2;
                trial = (lamb_pkg::REM_W+2)'({root, 2'b01});
                if (rem2 >= trial)
                begin
                    rem2 = rem2 - trial;
                    root = {root[lamb_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    root = {root[lamb_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            rad_next[k]  = rad;
            rem_next[k]  = rem2[lamb_pkg::REM_W-1:0];
            root_next[k] = root;
        end
    end

    // (m * 2^16 + len / 2) / len, two quotient bits per stage
    always_comb
    begin
        logic [lamb_pkg::M_W+16:0]  num;
        logic [lamb_pkg::DR_W-1:0]  r;
        logic [lamb_pkg::NB_W-1:0]  nb;
        logic [lamb_pkg::NB_W-1:0]  q;
        logic [lamb_pkg::LEN_W-1:0] len;
        num = '0;
        r = '0;
        nb = '0;
        q = '0;
        len = '0;
        for (int k = 0; k < lamb_pkg::DV_ST; k++)
        begin
            if (k == 0)
            begin
                len = root_reg[lamb_pkg::SQ_ST-1][lamb_pkg::LEN_W-1:0];
            end
            else
            begin
                len = len_reg[k-1];
            end
            len_next[k] = len;
            for (int i = 0; i < 3; i++)
            begin
                if (k == 0)
                begin
                    num = {1'b0, sm_reg[lamb_pkg::SQ_ST-1][i], 16'h0000}
                        + (lamb_pkg::M_W+17)'(len >> 1);
                    r   = lamb_pkg::DR_W'(num[lamb_pkg::M_W+16:lamb_pkg::NB_W]);
                    nb  = num[lamb_pkg::NB_W-1:0];
                    q   = '0;
                end
                else
                begin
                    r  = dr_reg[k-1][i];
                    nb = nb_reg[k-1][i];
                    q  = q_reg[k-1][i];
                end
                for (int j = 0; j < 2; j++)
                begin
                    r  = {r[lamb_pkg::DR_W-2:0], nb[lamb_pkg::NB_W-1]};
                    nb = nb << 1;
                    if (r >= lamb_pkg::DR_W'(len))
                    begin
                        r = r - lamb_pkg::DR_W'(len);
                        q = {q[lamb_pkg::NB_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[lamb_pkg::NB_W-2:0], 1'b0};
                    end
                end
                dr_next[k][i] = r;
                nb_next[k][i] = nb;
                q_next[k][i]  = q;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (dz_reg[lamb_pkg::DV_ST-1])
            begin
                out_next[i] = '0;
            end
            else if (dn_reg[lamb_pkg::DV_ST-1][i])
            begin
                out_next[i] = -q_reg[lamb_pkg::DV_ST-1][i];
            end
            else
            begin
                out_next[i] = q_reg[lamb_pkg::DV_ST-1][i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            mag1_reg  <= mag_reg;
            neg1_reg  <= neg_reg;
            mx_reg    <= mx_next;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            pos_reg   <= pos_next;
            zero_reg  <= zero_next;
            m_reg     <= m_next;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero_reg;
            sqr_reg   <= sqr_next;
            m4_reg    <= m_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            sum_reg   <= sum_next;
            m5_reg    <= m4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            for (int k = 0; k < lamb_pkg::SQ_ST; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                if (k == 0)
                begin
                    sm_reg[k] <= m5_reg;
                    sn_reg[k] <= neg5_reg;
                    sz_reg[k] <= zero5_reg;
                end
                else
                begin
                    sm_reg[k] <= sm_reg[k-1];
                    sn_reg[k] <= sn_reg[k-1];
                    sz_reg[k] <= sz_reg[k-1];
                end
            end
            for (int k = 0; k < lamb_pkg::DV_ST; k++)
            begin
                dr_reg[k]  <= dr_next[k];
                nb_reg[k]  <= nb_next[k];
                q_reg[k]   <= q_next[k];
                len_reg[k] <= len_next[k];
                if (k == 0)
                begin
                    dn_reg[k] <= sn_reg[lamb_pkg::SQ_ST-1];
                    dz_reg[k] <= sz_reg[lamb_pkg::SQ_ST-1];
                end
                else
                begin
                    dn_reg[k] <= dn_reg[k-1];
                    dz_reg[k] <= dz_reg[k-1];
                end
            end
            out_reg <= out_next;
        end
    end

    assign nvec = out_reg;

endmodule

/* dv/testbench.sv */
// Testbench for the look-at camera-to-world matrix builder.
// Drives eye/target/up words into the slave port and checks each matrix row word
// against a built-in fixed-point predictor. Depends on the top level only.
module testbench;

    localparam int ONE = 65536;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] c0, c1, c2, c3;
        logic        degen;
        logic        last;
    } row_word_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;

    logic [287:0] pending_words[$];
    row_word_t    expected_rows[$];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_off_cycles;
    bit           hold_off_req;
    bit           in_acc;
    int           errors;
    int           cycle_cnt;

    look_at_matrix_builder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // scale so the largest magnitude sits in [2^29, 2^30), then divide by length
    function automatic void normalize(input longint c[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned len;
        longint q;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = c[i] < 0 ? -c[i] : c[i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            o = '{0, 0, 0};
            return;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] * ONE + len / 2) / len;
            o[i] = c[i] < 0 ? -q : q;
        end
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Q32.32 to Q16.16, half away from zero
    function automatic longint round_q16(longint v);
        longint unsigned m;
        longint r;
        m = v < 0 ? -v : v;
        r = (m + 64'h8000) >> 16;
        return v < 0 ? -r : r;
    endfunction

    task automatic predict_matrix(input logic [287:0] w);
        longint eye[3], dif[3], upv[3], dir[3], upn[3], cr[3], lft[3], nu[3];
        longint mat[4][4];
        bit dg;
        row_word_t rw;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'($signed(w[32*i +: 32]));
            dif[i] = longint'($signed(w[32*(i+3) +: 32])) - eye[i];
            upv[i] = longint'($signed(w[32*(i+6) +: 32]));
        end
        normalize(dif, dir);
        normalize(upv, upn);
        cross3(upn, dir, cr);
        dg = (cr[0] == 0 && cr[1] == 0 && cr[2] == 0);
        for (int r = 0; r < 4; r++)
            for (int i = 0; i < 4; i++)
                mat[r][i] = 0;
        if (dg)
        begin
            for (int r = 0; r < 4; r++)
                mat[r][r] = ONE;
        end
        else
        begin
            normalize(cr, lft);
            cross3(dir, lft, nu);
            for (int r = 0; r < 3; r++)
            begin
                mat[r][0] = lft[r];
                mat[r][1] = round_q16(nu[r]);
                mat[r][2] = dir[r];
                mat[r][3] = eye[r];
            end
            mat[3][3] = ONE;
        end
        for (int r = 0; r < 4; r++)
        begin
            rw.row = r[1:0];
            rw.c0 = mat[r][0][31:0];
            rw.c1 = mat[r][1][31:0];
            rw.c2 = mat[r][2][31:0];
            rw.c3 = mat[r][3][31:0];
            rw.degen = dg;
            rw.last = (r == 3);
            expected_rows.push_back(rw);
        end
    endtask

    function automatic logic [287:0] pack_word(logic [31:0] e[3], logic [31:0] t[3],
                                               logic [31:0] u[3]);
        return {u[2], u[1], u[0], t[2], t[1], t[0], e[2], e[1], e[0]};
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    function automatic logic [287:0] rand_word();
        logic [31:0] e[3], t[3], u[3];
        int k;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = rand_coord();
            t[i] = rand_coord();
            u[i] = rand_coord();
        end
        k = $urandom_range(0, 9);
        if (k == 0)
            t = e;                       // target on the eye
        else if (k == 1)
            u = '{0, 0, 0};              // no up hint
        else if (k == 2)
            for (int i = 0; i < 3; i++)  // up along the view line
                u[i] = t[i] - e[i];
        return pack_word(e, t, u);
    endfunction

    // driver: next word presented at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || in_acc)
        begin
            if (in_acc)
                void'(pending_words.pop_front());
            if (pending_words.size() > (in_acc ? 1 : 0)
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_words[in_acc ? 1 : 0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // predict on acceptance, at the rising edge; the driver sees the flag
    always @(posedge clk)
    begin
        in_acc <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            predict_matrix(s_tdata);
    end

    // receiver ready, with a long hold-off on request
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= 0;
        end
        else if (hold_off_req && hold_off_cycles == 0)
        begin
            hold_off_cycles <= 600;
            m_tready <= 1'b0;
        end
        else if (hold_off_cycles > 1)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            if (hold_off_cycles == 1)
                hold_off_cycles <= -1;
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        row_word_t x;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("row word with no expectation: %h", m_tdata);
                errors++;
            end
            else
            begin
                x = expected_rows.pop_front();
                if (m_tdata[1:0] !== x.row)
                begin
                    $error("row_index exp %0d got %0d", x.row, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[33:2] !== x.c0)
                begin
                    $error("col_zero exp %h got %h", x.c0, m_tdata[33:2]);
                    errors++;
                end
                if (m_tdata[65:34] !== x.c1)
                begin
                    $error("col_one exp %h got %h", x.c1, m_tdata[65:34]);
                    errors++;
                end
                if (m_tdata[97:66] !== x.c2)
                begin
                    $error("col_two exp %h got %h", x.c2, m_tdata[97:66]);
                    errors++;
                end
                if (m_tdata[129:98] !== x.c3)
                begin
                    $error("col_three exp %h got %h", x.c3, m_tdata[129:98]);
                    errors++;
                end
                if (m_tuser[0] !== x.degen)
                begin
                    $error("degenerate exp %0d got %0d", x.degen, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== x.last)
                begin
                    $error("last_row exp %0d got %0d", x.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_rows.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] e[3], t[3], u[3];
        errors = 0;
        cycle_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_req = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: plain camera, extremes, zero vectors, parallel up
        e = '{0, 0, 0}; t = '{0, 0, 32'hFFFF_0000}; u = '{0, ONE, 0};
        pending_words.push_back(pack_word(e, t, u));
        e = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        t = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        u = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        pending_words.push_back(pack_word(e, t, u));
        pending_words.push_back(pack_word(t, e, e));
        pending_words.push_back(pack_word(t, t, u));                 // target on eye
        e = '{1, 2, 3}; t = '{4, 5, 6};
        pending_words.push_back(pack_word(e, t, '{0, 0, 0}));       // no up hint
        pending_words.push_back(pack_word(e, t, '{3, 3, 3}));       // up parallel
        pending_words.push_back(pack_word(e, t, '{32'hFFFF_FFFD, 32'hFFFF_FFFD,
                                                  32'hFFFF_FFFD})); // antiparallel
        pending_words.push_back(pack_word('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
        pending_words.push_back({288{1'b1}});
        pending_words.push_back({144{2'b10}});
        pending_words.push_back({144{2'b01}});
        e = '{ONE, 0, 0}; t = '{0, ONE, 0}; u = '{0, 0, 1};
        pending_words.push_back(pack_word(e, t, u));
        wait_drained();

        // random phases with different idle mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 76 : 22) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 76 : 22) : 0;
            for (int i = 0; i < 50; i++)
                pending_words.push_back(rand_word());
            if (ph == 0)
                hold_off_req = 1;    // sender keeps offering through a long stall
            wait_drained();
            hold_off_req = 0;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_rows.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* look_at_matrix_builder_top.f */
+incdir+rtl
rtl/lamb_pkg.sv
rtl/lamb_norm.sv
rtl/look_at_matrix_builder_top.sv
dv/testbench.sv
